// ----- hdl/ihc_pkg.sv -----
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 header checker.
// ----------------------------------------------------------------------------
package ihc_pkg;

    // Verdict codes, first failing check wins
    typedef enum logic [2:0] {
        VERDICT_ACCEPT   = 3'd0,
        VERDICT_TTL      = 3'd1,
        VERDICT_VERSION  = 3'd2,
        VERDICT_HDR_LEN  = 3'd3,
        VERDICT_DEST     = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } t_verdict;

    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [5:0]  POS_VER_IHL   = 6'd0;
    localparam logic [5:0]  POS_TTL       = 6'd8;
    localparam logic [5:0]  POS_DST_FIRST = 6'd16;
    localparam logic [5:0]  POS_DST_LAST  = 6'd19;
    localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;
    localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

    // Result of one header byte, parser to top level
    typedef struct packed {
        logic       valid;
        t_verdict   verdict;
        logic [5:0] header_bytes;
    } t_ihc_result;

endpackage

// ----- hdl/ihc_ifs.sv -----
// ----------------------------------------------------------------------------
// ihc_ifs
// Valid/ready channels: packet bytes in, header verdicts out.
// ----------------------------------------------------------------------------

// Packet byte stream, one byte per word
interface ihc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       start_of_packet;

    modport source (output valid, packet_byte, start_of_packet, input ready);
    modport sink   (input valid, packet_byte, start_of_packet, output ready);
endinterface

// Verdict stream, one word per header
interface ihc_verdict_if import ihc_pkg::*; ;
    logic       valid;
    logic       ready;
    t_verdict   verdict;
    logic [5:0] header_bytes;

    modport source (output valid, verdict, header_bytes, input ready);
    modport sink   (input valid, verdict, header_bytes, output ready);
endinterface

// ----- hdl/ihc_parser.sv -----
// ----------------------------------------------------------------------------
// ihc_parser
// Per-packet header state: field capture, ones' complement sum, verdict.
// ----------------------------------------------------------------------------
module ihc_parser import ihc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,       // byte in the input register is consumed
    input  logic [7:0]  i_byte,
    input  logic        i_sop,
    input  logic [31:0] i_local_addr,
    output t_ihc_result o_res
);

    logic        r_done;
    logic [5:0]  r_pos;
    logic [3:0]  r_ihl;
    logic [3:0]  r_ver;
    logic [7:0]  r_ttl;
    logic [31:0] r_dst;
    logic [15:0] r_sum;
    logic [7:0]  r_pend;

    logic        active;
    logic [5:0]  pos;
    logic [5:0]  n_pos;
    logic [3:0]  n_ihl;
    logic [3:0]  n_ver;
    logic [7:0]  n_ttl;
    logic [31:0] n_dst;
    logic [15:0] sum_base;
    logic [16:0] sum_wide;
    logic [15:0] sum_fold;
    logic [15:0] n_sum;
    logic [5:0]  ihl_bytes;
    logic [5:0]  hdr_len;
    logic        fire;
    t_verdict    verdict;

    // Byte position and header fields after this byte
    assign active = i_sop | ~r_done;
    assign pos    = i_sop ? POS_VER_IHL : r_pos;
    assign n_pos  = pos + 6'd1;
    assign n_ihl  = (pos == POS_VER_IHL) ? i_byte[3:0] : r_ihl;
    assign n_ver  = (pos == POS_VER_IHL) ? i_byte[7:4] : r_ver;
    assign n_ttl  = (pos == POS_TTL) ? i_byte : r_ttl;
    assign n_dst  = (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) ?
                    {r_dst[23:0], i_byte} : r_dst;

    // Ones' complement add of each completed 16-bit word
    assign sum_base = i_sop ? 16'd0 : r_sum;
    assign sum_wide = {1'b0, sum_base} + {1'b0, r_pend, i_byte};
    assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
    assign n_sum    = pos[0] ? sum_fold : sum_base;

    // Header ends after max(20, IHL*4) bytes
    assign ihl_bytes = {n_ihl, 2'b00};
    assign hdr_len   = (ihl_bytes < MIN_HDR_BYTES) ? MIN_HDR_BYTES : ihl_bytes;
    assign fire      = active && (n_pos >= hdr_len);

    // Checks in priority order
    always_comb begin
        priority if (n_ttl == 8'd0) begin
            verdict = VERDICT_TTL;
        end else if (n_ver != IPV4_VERSION) begin
            verdict = VERDICT_VERSION;
        end else if (n_ihl < MIN_IHL) begin
            verdict = VERDICT_HDR_LEN;
        end else if (n_dst != i_local_addr && n_dst != BCAST_ADDR) begin
            verdict = VERDICT_DEST;
        end else if (n_sum != SUM_GOOD) begin
            verdict = VERDICT_CHECKSUM;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    assign o_res.valid        = fire;
    assign o_res.verdict      = verdict;
    assign o_res.header_bytes = hdr_len;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b1;
            r_pos  <= '0;
        end else if (i_step && active) begin
            r_done <= fire;
            r_pos  <= n_pos;
        end
    end

    // Header fields; start of packet overwrites everything before use
    always_ff @(posedge i_clk) begin
        if (i_step && active) begin
            r_ihl <= n_ihl;
            r_ver <= n_ver;
            r_ttl <= n_ttl;
            r_dst <= n_dst;
            r_sum <= n_sum;
            if (!pos[0]) begin
                r_pend <= i_byte;
            end
        end
    end

endmodule

// ----- hdl/ipv4_header_checker.sv -----
// Output: the last header byte is accepted into the input register, and its verdict word is then
//   registered in the result register (input register, then result register) and held until taken.
// Throughput: one packet byte per cycle while the verdict sink does not stall; the field/sum update is combinational.
// Reset: synchronous, active low; local address clears to 0 and the checker waits
//   for a start-of-packet byte; all other bytes are dropped until then.
// ----------------------------------------------------------------------------
// ipv4_header_checker
// Checks IPv4 headers byte by byte and gives one verdict per completed header.
// ----------------------------------------------------------------------------
module ipv4_header_checker import ihc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    ihc_byte_if.sink     i_pkt,
    ihc_verdict_if.source o_res
);

    logic [31:0] r_local_addr;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_sop;
    logic        r_out_valid;
    t_verdict    r_out_verdict;
    logic [5:0]  r_out_hdr;

    logic        advance;
    t_ihc_result res;

    // Local address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
        end else if (i_cfg_we) begin
            r_local_addr <= i_cfg_wdata;
        end
    end

    // Handshake between the input and result registers
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pkt.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.ready && i_pkt.valid) begin
            r_in_byte <= i_pkt.packet_byte;
            r_in_sop  <= i_pkt.start_of_packet;
        end
    end

    ihc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .i_sop        (r_in_sop),
        .i_local_addr (r_local_addr),
        .o_res        (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res.valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_verdict <= res.verdict;
            r_out_hdr     <= res.header_bytes;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.verdict      = r_out_verdict;
    assign o_res.header_bytes = r_out_hdr;

`ifndef SYNTH
    // Header length stays within 20..60 bytes
    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_hdr >= MIN_HDR_BYTES && r_out_hdr <= 6'd60))
        else $error("header length out of range");

    // Input stalls only when both registers are full and the sink is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pkt.ready |-> (r_in_valid && r_out_valid && !o_res.ready))
        else $error("input stalled without back pressure");

    // An accepted header is never shorter than 20 bytes and never ends on a start byte
    a_short_ihl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res.valid && res.verdict == VERDICT_ACCEPT) |->
            (res.header_bytes >= MIN_HDR_BYTES && !r_in_sop))
        else $error("accept on malformed header");

    // A stalled verdict word holds still until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=>
            (r_out_valid && $stable(r_out_verdict) && $stable(r_out_hdr)))
        else $error("verdict word changed while stalled");
`endif

endmodule

// ----- bench/ipv4_header_checker_tb.sv -----
// ----------------------------------------------------------------------------
// ipv4_header_checker_tb
// Self-checking bench for the IPv4 header checker. Packet bytes go in over a
// valid/ready channel with random gaps; a scoreboard class rebuilds each
// header verdict from the accepted bytes and compares it with every verdict
// word the block returns, field by field, in order.
// ----------------------------------------------------------------------------
module ipv4_header_checker_tb;
    import ihc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One expected verdict word
    typedef struct {
        t_verdict   verdict;
        logic [5:0] header_bytes;
    } t_verdict_word;

    // Tracks header state from accepted bytes and holds the verdicts still owed
    class t_verdict_tracker;
        logic [31:0]   local_addr;
        logic [5:0]    byte_pos;
        logic [3:0]    ihl;
        logic [3:0]    version;
        logic [7:0]    ttl;
        logic [31:0]   dest;
        logic [15:0]   sum;
        logic [7:0]    high_byte;
        bit            idle;
        t_verdict_word owed[$];
        int            errors;
        int            header_bytes_taken;

        function new();
            local_addr         = '0;
            errors             = 0;
            header_bytes_taken = 0;
            idle               = 1'b1;
            clear_header();
        endfunction

        function void clear_header();
            byte_pos  = '0;
            ihl       = '0;
            version   = '0;
            ttl       = '0;
            dest      = '0;
            sum       = '0;
            high_byte = '0;
        endfunction

        function void set_local_address(logic [31:0] addr);
            local_addr = addr;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // max(20, IHL*4)
        function logic [5:0] header_len();
            logic [5:0] len;
            len = {ihl, 2'b00};
            return (len < MIN_HDR_BYTES) ? MIN_HDR_BYTES : len;
        endfunction

        // First failing check wins
        function t_verdict judge();
            if (ttl == 8'd0)
                return VERDICT_TTL;
            if (version != IPV4_VERSION)
                return VERDICT_VERSION;
            if (ihl < MIN_IHL)
                return VERDICT_HDR_LEN;
            if (dest != local_addr && dest != BCAST_ADDR)
                return VERDICT_DEST;
            if (sum != SUM_GOOD)
                return VERDICT_CHECKSUM;
            return VERDICT_ACCEPT;
        endfunction

        // Called for every accepted byte word
        function void take_byte(logic [7:0] b, bit sop);
            logic [16:0] s;
            if (sop) begin
                // start always restarts, even mid-header
                clear_header();
                idle = 1'b0;
            end else if (idle) begin
                return;
            end
            header_bytes_taken++;

            if (byte_pos == POS_VER_IHL) begin
                version = b[7:4];
                ihl     = b[3:0];
            end
            if (byte_pos == POS_TTL)
                ttl = b;
            if (byte_pos >= POS_DST_FIRST && byte_pos <= POS_DST_LAST)
                dest = {dest[23:0], b};

            // big-endian words, end-around carry
            if (!byte_pos[0]) begin
                high_byte = b;
            end else begin
                s   = {1'b0, sum} + {1'b0, high_byte, b};
                sum = s[15:0] + {15'd0, s[16]};
            end

            byte_pos = byte_pos + 6'd1;
            if (byte_pos >= header_len()) begin
                idle = 1'b1;
                owed.push_back('{judge(), header_len()});
            end
        endfunction

        // Called for every accepted verdict word
        function void match_verdict(t_verdict v, logic [5:0] hb);
            t_verdict_word want;
            if (owed.size() == 0) begin
                $error("unexpected verdict word: verdict %0d, header_bytes %0d", v, hb);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (v !== want.verdict) begin
                $error("verdict: expected %0d, actual %0d", want.verdict, v);
                errors++;
            end
            if (hb !== want.header_bytes) begin
                $error("header_bytes: expected %0d, actual %0d", want.header_bytes, hb);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    ihc_byte_if    byte_ch ();
    ihc_verdict_if verdict_ch ();

    t_verdict_tracker sb = new();

    bit          tx_busy;
    bit          rx_busy;
    bit          hold_req;
    logic [31:0] cur_addr;

    ipv4_header_checker uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pkt       (byte_ch),
        .o_res       (verdict_ch)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("ipv4_header_checker_tb: FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(bit busy);
        int r;
        if (!busy)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus one long hold on request
    initial begin
        int stall_left;
        verdict_ch.ready = 1'b0;
        stall_left       = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                verdict_ch.ready = 1'b0;
                repeat (300) @(negedge clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                verdict_ch.ready = 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(rx_busy);
                verdict_ch.ready = (stall_left == 0);
            end
        end
    end

    // Verdict monitor
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && verdict_ch.valid === 1'b1 && verdict_ch.ready)
                sb.match_verdict(verdict_ch.verdict, verdict_ch.header_bytes);
        end
    end

    // Offer one byte word and wait until it is taken
    task automatic put_word(input logic [7:0] b, input bit sop);
        int gap;
        gap = pick_gap(tx_busy);
        if (gap > 0) begin
            @(negedge clk);
            byte_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_ch.valid           = 1'b1;
        byte_ch.packet_byte     = b;
        byte_ch.start_of_packet = sop;
        do @(posedge clk); while (!byte_ch.ready);
        sb.take_byte(b, sop);
    endtask

    // Non-start bytes, ignored while no header is open
    task automatic send_noise(input int n);
        repeat (n) put_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Build a header with a correct checksum (optionally spoiled), send the
    // first cut bytes (0 = all), then payload bytes
    task automatic send_header(input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [7:0] ttl, input logic [31:0] dst,
                               input bit bad_sum, input int cut, input int payload);
        logic [7:0]  frame[$];
        logic [16:0] s;
        logic [15:0] hsum;
        int          len;
        int          i;
        len = (ihl < MIN_IHL) ? 20 : int'(ihl) * 4;
        for (i = 0; i < len; i++)
            frame.push_back(8'($urandom_range(0, 255)));
        frame[0]  = {ver, ihl};
        frame[8]  = ttl;
        frame[10] = 8'h00;
        frame[11] = 8'h00;
        for (i = 0; i < 4; i++)
            frame[16 + i] = dst[31 - 8 * i -: 8];
        hsum = '0;
        for (i = 0; i < len; i += 2) begin
            s    = {1'b0, hsum} + {1'b0, frame[i], frame[i + 1]};
            hsum = s[15:0] + {15'd0, s[16]};
        end
        hsum      = ~hsum;
        frame[10] = hsum[15:8];
        frame[11] = hsum[7:0];
        if (bad_sum)
            frame[10 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        if (cut <= 0 || cut > len)
            cut = len;
        for (i = 0; i < cut; i++)
            put_word(frame[i], i == 0);
        send_noise(payload);
    endtask

    // Mostly well-formed headers to the local or broadcast address
    task automatic random_header(input bit may_cut);
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [7:0]  ttl;
        logic [31:0] dst;
        bit          bad;
        int          r;
        int          len;
        int          cut;
        int          payload;
        ver = IPV4_VERSION;
        r   = $urandom_range(0, 99);
        ihl = (r < 80) ? 4'd5 : (r < 95) ? 4'($urandom_range(6, 14)) : 4'd15;
        ttl = 8'($urandom_range(1, 255));
        dst = ($urandom_range(0, 9) < 7) ? cur_addr : BCAST_ADDR;
        bad = 1'b0;
        r   = $urandom_range(0, 99);
        if (r >= 95) begin
            ver = 4'($urandom);
            ihl = 4'($urandom);
            ttl = 8'($urandom);
            dst = $urandom;
            bad = 1'($urandom);
        end else if (r >= 88) begin
            bad = 1'b1;
        end else if (r >= 81) begin
            dst = $urandom;
        end else if (r >= 74) begin
            ihl = 4'($urandom_range(0, 4));
        end else if (r >= 67) begin
            ver = 4'($urandom_range(0, 15));
        end else if (r >= 60) begin
            ttl = 8'd0;
        end
        len = (ihl < MIN_IHL) ? 20 : int'(ihl) * 4;
        cut = 0;
        if (may_cut && $urandom_range(0, 9) == 0)
            cut = $urandom_range(1, len - 1);
        r = $urandom_range(0, 99);
        payload = (r < 60) ? $urandom_range(0, 6) : (r < 70) ? $urandom_range(20, 40) : 0;
        send_header(ver, ihl, ttl, dst, bad, cut, payload);
        if (cut == 0 && $urandom_range(0, 9) == 0)
            send_noise($urandom_range(1, 4));
    endtask

    // Drop valid, wait out every owed verdict and the pipeline behind it
    task automatic settle();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_local_address(input logic [31:0] addr);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = addr;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_local_address(addr);
        cur_addr = addr;
    endtask

    // Main sequence
    initial begin
        logic [31:0] phase_addr[5];
        int          start_cnt;
        int          n;
        int          p;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        byte_ch.valid           = 1'b0;
        byte_ch.packet_byte     = '0;
        byte_ch.start_of_packet = 1'b0;
        tx_busy                 = 1'b1;
        rx_busy                 = 1'b1;
        hold_req                = 1'b0;
        cur_addr                = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed headers, local address still at its reset value
        put_word(8'h00, 1'b0);
        put_word(8'hFF, 1'b0);
        send_header(IPV4_VERSION, 4'd5, 8'hFF, 32'h0, 1'b0, 0, 3);
        send_header(IPV4_VERSION, 4'd5, 8'h01, BCAST_ADDR, 1'b0, 0, 0);
        // zero TTL wins over every other fault
        send_header(4'hF, 4'd0, 8'h00, 32'h1234_5678, 1'b1, 0, 0);
        send_header(4'h6, 4'd3, 8'h40, 32'h0, 1'b1, 0, 0);
        // short IHL: still 20 bytes, beats destination check
        send_header(IPV4_VERSION, 4'd0, 8'h40, 32'h0A00_0001, 1'b1, 0, 0);
        send_header(IPV4_VERSION, 4'd4, 8'h40, 32'h0, 1'b0, 0, 0);
        // longest header
        send_header(IPV4_VERSION, 4'd15, 8'h80, 32'h0, 1'b0, 0, 2);
        send_header(IPV4_VERSION, 4'd5, 8'h40, 32'hC0A8_0001, 1'b1, 0, 0);
        send_header(IPV4_VERSION, 4'd5, 8'h40, 32'h0, 1'b1, 0, 0);
        // restart mid-header, and on the last header byte
        send_header(IPV4_VERSION, 4'd6, 8'h40, 32'h0, 1'b0, 10, 0);
        send_header(IPV4_VERSION, 4'd5, 8'h7F, BCAST_ADDR, 1'b0, 19, 0);
        send_header(IPV4_VERSION, 4'd7, 8'h33, 32'h0, 1'b0, 0, 1);
        settle();

        // Random phases, each with its own address and idling mix
        phase_addr[0] = 32'hFFFF_FFFF;
        phase_addr[1] = $urandom;
        phase_addr[2] = $urandom;
        phase_addr[3] = 32'h0;
        phase_addr[4] = $urandom;
        for (p = 0; p < 5; p++) begin
            write_local_address(phase_addr[p]);
            tx_busy = (p == 0 || p >= 3);
            rx_busy = (p != 1 && p != 3);
            // long receiver hold while bytes keep coming back to back
            if (p == 2)
                hold_req = 1'b1;
            start_cnt = sb.header_bytes_taken;
            n = 0;
            while (sb.header_bytes_taken - start_cnt < 100 || n < 4) begin
                random_header(1'b1);
                n++;
            end
            random_header(1'b0);
            settle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ipv4_header_checker_tb: PASS");
        end else begin
            $display("ipv4_header_checker_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ihc_pkg.sv
hdl/ihc_ifs.sv
hdl/ihc_parser.sv
hdl/ipv4_header_checker.sv
bench/ipv4_header_checker_tb.sv
